FILE: src/rbj_pkg.sv
package rbj_pkg;

    // Default widths of the time and failure count datapaths
    localparam int P_TIME_WIDTH  = 32;
    localparam int P_COUNT_WIDTH = 16;

    // Field widths of the channels
    localparam int OP_W         = 3;
    localparam int ACT_W        = 3;
    localparam int FIELD_TIME_W = 32;
    localparam int PCT_W        = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    // Percent scaling: full scale and the divisor of the digit unit
    localparam logic [PCT_W-1:0] PCT_FULL  = 8'd100;
    localparam int               DIV_CONST = 100;

    typedef enum logic [OP_W-1:0] {
        OP_REQUEST,
        OP_ACCEPTED,
        OP_RETRY_FAIL,
        OP_TERM_FAIL,
        OP_CLEAR
    } t_op;

    typedef enum logic [ACT_W-1:0] {
        ACT_STOP,
        ACT_START,
        ACT_IN_FLIGHT,
        ACT_RETRY,
        ACT_NONE
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INITIAL,
        CFG_MAX,
        CFG_JITTER
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DOUBLE,
        ST_LO_GO,
        ST_LO_WAIT,
        ST_HI_GO,
        ST_HI_WAIT,
        ST_SP_GO,
        ST_SP_WAIT,
        ST_DONE
    } t_state;

endpackage

FILE: src/rbj_ifs.sv
interface rbj_req_if import rbj_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         op;
    logic [FIELD_TIME_W-1:0] server_hint;
    logic [PCT_W-1:0]        jitter_pick;

    modport source (output valid, op, server_hint, jitter_pick, input ready);
    modport sink   (input valid, op, server_hint, jitter_pick, output ready);
endinterface

interface rbj_rsp_if import rbj_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [ACT_W-1:0]        action;
    logic [FIELD_TIME_W-1:0] delay;

    modport source (output valid, action, delay, input ready);
    modport sink   (input valid, action, delay, output ready);
endinterface

interface rbj_cfg_if import rbj_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/rbj_scale.sv
module rbj_scale import rbj_pkg::*; #(
    parameter int TIME_WIDTH = P_TIME_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [TIME_WIDTH-1:0] i_x,
    input  logic [PCT_W-1:0]      i_k,
    output logic                  o_done,
    output logic [TIME_WIDTH-1:0] o_result
);

    localparam int PROD_W     = TIME_WIDTH + PCT_W;
    localparam int STEPS      = (PROD_W + 7) / 8;
    localparam int PAD_W      = STEPS * 8;
    localparam int STEP_CNT_W = $clog2(STEPS + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_CNT_W-1:0] r_cnt;
    logic [PAD_W-1:0]      r_num;
    logic [PAD_W-1:0]      r_quo;
    logic [6:0]            r_rem;

    logic [PROD_W-1:0]     w_prod;
    logic [PAD_W-1:0]      n_num;
    logic [PAD_W-1:0]      n_quo;
    logic [6:0]            n_rem;

    // Product of the value and the percent factor
    assign w_prod = PROD_W'(i_x) * PROD_W'(i_k);

    // Eight restoring steps of division by the constant, one bit each
    always_comb begin
        logic [7:0] t;
        logic       qbit;
        n_num = r_num;
        n_quo = r_quo;
        n_rem = r_rem;
        for (int j = 0; j < 8; j++) begin
            t     = {n_rem, n_num[PAD_W-1]};
            n_num = {n_num[PAD_W-2:0], 1'b0};
            if (t >= 8'(DIV_CONST)) begin
                t    = t - 8'(DIV_CONST);
                qbit = 1'b1;
            end else begin
                qbit = 1'b0;
            end
            n_rem = t[6:0];
            n_quo = {n_quo[PAD_W-2:0], qbit};
        end
    end

    // Sequence the division passes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_CNT_W'(STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Load the product, then shift digits through
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= PAD_W'(w_prod);
            r_quo <= '0;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= n_num;
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    // Saturate the quotient to the time width
    assign o_done   = r_done;
    assign o_result = (|r_quo[PAD_W-1:TIME_WIDTH]) ? '1 : r_quo[TIME_WIDTH-1:0];

endmodule

FILE: src/retry_backoff_with_jitter_core.sv
// Ops other than a retryable failure with no server hint are answered from the output register
// the cycle after they are accepted. Such a failure runs at most min(failure count, TIME_WIDTH)
// doubling steps, then with jitter on two percent passes (three when the band is not empty)
// through one shared multiply-divide unit. Throughput: one request at a time, taken only in idle.
// Reset (synchronous, active low) clears the state, configuration, flags, count and response valid.
module retry_backoff_with_jitter_core import rbj_pkg::*; #(
    parameter int TIME_WIDTH  = P_TIME_WIDTH,
    parameter int COUNT_WIDTH = P_COUNT_WIDTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    rbj_req_if.sink   i_req,
    rbj_rsp_if.source o_rsp,
    rbj_cfg_if.sink   i_cfg
);

    t_state r_state;
    t_state n_state;

    // Configuration
    logic [CFG_DATA_W-1:0] r_init;
    logic [CFG_DATA_W-1:0] r_max;
    logic [PCT_W-1:0]      r_jit;

    // Controller state
    logic                   r_in_flight;
    logic                   r_rerun;
    logic [COUNT_WIDTH-1:0] r_fail_cnt;
    logic                   n_in_flight;
    logic                   n_rerun;
    logic [COUNT_WIDTH-1:0] n_fail_cnt;

    // Delay computation
    logic [COUNT_WIDTH-1:0] r_cnt_snap;
    logic [COUNT_WIDTH-1:0] r_iter;
    logic                   r_stop;
    logic [TIME_WIDTH-1:0]  r_d;
    logic [TIME_WIDTH-1:0]  r_lower;
    logic [TIME_WIDTH-1:0]  r_span;
    logic [TIME_WIDTH-1:0]  r_res;
    logic [PCT_W-1:0]       r_pick;

    // Output register
    logic                    r_out_valid;
    logic [ACT_W-1:0]        r_out_action;
    logic [FIELD_TIME_W-1:0] r_out_delay;

    logic [63:0]             w_init_ext;
    logic [63:0]             w_max_ext;
    logic [63:0]             w_hint_ext;
    logic [63:0]             w_time_ext;
    logic [TIME_WIDTH-1:0]   w_init;
    logic [TIME_WIDTH-1:0]   w_max;
    logic [TIME_WIDTH-1:0]   w_cap;
    logic [TIME_WIDTH-1:0]   w_hint;
    logic [TIME_WIDTH-1:0]   w_out_time;
    logic [PCT_W-1:0]        w_jit;
    logic [PCT_W-1:0]        w_pick_sat;
    logic                    w_out_free;
    logic                    w_accept;
    logic                    w_calc;
    logic                    w_go_calc;
    logic                    w_load_out;
    logic                    w_dbl_exit;
    t_action                 w_act;
    logic [TIME_WIDTH-1:0]   w_dbl;
    logic [TIME_WIDTH-1:0]   w_step_d;
    logic                    w_step_stop;
    logic [TIME_WIDTH-1:0]   w_upper;
    logic [ACT_W-1:0]        w_out_action;
    logic [FIELD_TIME_W-1:0] w_out_delay;

    logic                  w_sc_start;
    logic [TIME_WIDTH-1:0] w_sc_x;
    logic [PCT_W-1:0]      w_sc_k;
    logic                  w_sc_done;
    logic [TIME_WIDTH-1:0] w_sc_res;

    // Narrow 32-bit fields to the time width
    assign w_init_ext = {32'd0, r_init};
    assign w_max_ext  = {32'd0, r_max};
    assign w_hint_ext = {32'd0, i_req.server_hint};
    assign w_init     = w_init_ext[TIME_WIDTH-1:0];
    assign w_max      = w_max_ext[TIME_WIDTH-1:0];
    assign w_hint     = w_hint_ext[TIME_WIDTH-1:0];
    assign w_cap      = (w_max == '0) ? w_init : w_max;

    // Saturate percentages at full scale
    assign w_jit      = (r_jit > PCT_FULL) ? PCT_FULL : r_jit;
    assign w_pick_sat = (i_req.jitter_pick > PCT_FULL) ? PCT_FULL : i_req.jitter_pick;

    // Handshakes
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept    = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;

    // Decode the op into flag updates and the immediate action
    always_comb begin
        n_in_flight = r_in_flight;
        n_rerun     = r_rerun;
        n_fail_cnt  = r_fail_cnt;
        w_act       = ACT_NONE;
        w_calc      = 1'b0;
        case (t_op'(i_req.op))
            OP_REQUEST: begin
                if (r_in_flight) begin
                    n_rerun = 1'b1;
                    w_act   = ACT_IN_FLIGHT;
                end else begin
                    n_in_flight = 1'b1;
                    w_act       = ACT_START;
                end
            end
            OP_ACCEPTED, OP_CLEAR: begin
                n_in_flight = 1'b0;
                n_rerun     = 1'b0;
                n_fail_cnt  = '0;
            end
            OP_RETRY_FAIL: begin
                if (r_rerun) begin
                    n_rerun     = 1'b0;
                    n_fail_cnt  = '0;
                    n_in_flight = 1'b1;
                    w_act       = ACT_START;
                end else begin
                    n_in_flight = 1'b0;
                    w_act       = ACT_RETRY;
                    w_calc      = 1'b1;
                    if (r_fail_cnt != '1) begin
                        n_fail_cnt = r_fail_cnt + 1'b1;
                    end
                end
            end
            OP_TERM_FAIL: begin
                n_in_flight = 1'b0;
                n_rerun     = 1'b0;
                w_act       = ACT_STOP;
            end
            default: begin
            end
        endcase
    end

    assign w_go_calc = w_accept && w_calc && (w_hint == '0);

    // One doubling step with cap
    assign w_dbl = {r_d[TIME_WIDTH-2:0], 1'b0};
    always_comb begin
        w_step_d    = r_d;
        w_step_stop = 1'b0;
        if (r_d > (w_cap >> 1)) begin
            w_step_d    = w_cap;
            w_step_stop = 1'b1;
        end else if (r_d == '0) begin
            w_step_stop = 1'b1;
        end else if (w_dbl >= w_cap) begin
            w_step_d    = w_cap;
            w_step_stop = 1'b1;
        end else begin
            w_step_d = w_dbl;
        end
    end

    assign w_dbl_exit = r_stop || (r_iter == r_cnt_snap);
    assign w_upper    = (w_sc_res > w_cap) ? w_cap : w_sc_res;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_go_calc) begin
                    n_state = ST_DOUBLE;
                end
            end
            ST_DOUBLE: begin
                if (w_dbl_exit) begin
                    n_state = (w_jit == '0) ? ST_DONE : ST_LO_GO;
                end
            end
            ST_LO_GO:   n_state = ST_LO_WAIT;
            ST_LO_WAIT: begin
                if (w_sc_done) begin
                    n_state = ST_HI_GO;
                end
            end
            ST_HI_GO:   n_state = ST_HI_WAIT;
            ST_HI_WAIT: begin
                if (w_sc_done) begin
                    n_state = (w_upper <= r_lower) ? ST_DONE : ST_SP_GO;
                end
            end
            ST_SP_GO:   n_state = ST_SP_WAIT;
            ST_SP_WAIT: begin
                if (w_sc_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Drive the percent unit
    always_comb begin
        w_sc_start = 1'b0;
        w_sc_x     = r_d;
        w_sc_k     = '0;
        case (r_state)
            ST_LO_GO: begin
                w_sc_start = 1'b1;
                w_sc_k     = PCT_FULL - w_jit;
            end
            ST_HI_GO: begin
                w_sc_start = 1'b1;
                w_sc_k     = PCT_FULL + w_jit;
            end
            ST_SP_GO: begin
                w_sc_start = 1'b1;
                w_sc_x     = r_span;
                w_sc_k     = r_pick;
            end
            default: begin
            end
        endcase
    end

    // Response contents: immediate from decode, or the computed delay
    assign w_load_out = (w_accept && !w_go_calc) || ((r_state == ST_DONE) && w_out_free);
    assign w_out_time = (r_state == ST_DONE) ? r_res : w_hint;
    always_comb begin
        w_time_ext                 = '0;
        w_time_ext[TIME_WIDTH-1:0] = w_out_time;
        if (r_state == ST_DONE) begin
            w_out_action = ACT_RETRY;
            w_out_delay  = w_time_ext[FIELD_TIME_W-1:0];
        end else begin
            w_out_action = w_act;
            w_out_delay  = w_calc ? w_time_ext[FIELD_TIME_W-1:0] : '0;
        end
    end

    rbj_scale #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_sc_start),
        .i_x      (w_sc_x),
        .i_k      (w_sc_k),
        .o_done   (w_sc_done),
        .o_result (w_sc_res)
    );

    // Control state, configuration and response valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_init      <= '0;
            r_max       <= '0;
            r_jit       <= '0;
            r_in_flight <= 1'b0;
            r_rerun     <= 1'b0;
            r_fail_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_cfg_idx'(i_cfg.index))
                    CFG_INITIAL: r_init <= i_cfg.data;
                    CFG_MAX:     r_max  <= i_cfg.data;
                    CFG_JITTER:  r_jit  <= i_cfg.data[PCT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (w_accept) begin
                r_in_flight <= n_in_flight;
                r_rerun     <= n_rerun;
                r_fail_cnt  <= n_fail_cnt;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Delay datapath and response payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cnt_snap <= r_fail_cnt;
            r_iter     <= '0;
            r_stop     <= 1'b0;
            r_d        <= w_init;
            r_pick     <= w_pick_sat;
        end
        case (r_state)
            ST_DOUBLE: begin
                if (w_dbl_exit) begin
                    r_res <= r_d;
                end else begin
                    r_d    <= w_step_d;
                    r_stop <= w_step_stop;
                    r_iter <= r_iter + 1'b1;
                end
            end
            ST_LO_WAIT: begin
                if (w_sc_done) begin
                    r_lower <= (w_sc_res < w_init) ? w_init : w_sc_res;
                end
            end
            ST_HI_WAIT: begin
                if (w_sc_done) begin
                    r_res  <= r_lower;
                    r_span <= w_upper - r_lower;
                end
            end
            ST_SP_WAIT: begin
                if (w_sc_done) begin
                    r_res <= r_lower + w_sc_res;
                end
            end
            default: begin
            end
        endcase
        if (w_load_out) begin
            r_out_action <= w_out_action;
            r_out_delay  <= w_out_delay;
        end
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.action = r_out_action;
    assign o_rsp.delay  = r_out_delay;

endmodule

FILE: sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rbj_pkg::*;

    localparam logic [31:0]      TIME_ALL        = 32'hFFFF_FFFF;
    localparam longint unsigned  PERCENT         = 100;
    localparam logic [OP_W-1:0]  OP_UNUSED_FIRST = OP_W'(OP_CLEAR) + OP_W'(1);
    localparam logic [OP_W-1:0]  OP_CODE_TOP     = '1;
    localparam int               SETTLE_CYCLES   = 64;
    localparam int               MAX_SHOWN       = 10;
    localparam int               DEEP_FAILS      = 40;
    localparam int               RANDOM_PHASES   = 7;
    localparam int               PHASE_ITEMS     = 272;

    typedef struct packed {
        t_action     action;
        logic [31:0] delay;
    } t_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rbj_req_if req_ch ();
    rbj_rsp_if rsp_ch ();
    rbj_cfg_if cfg_ch ();

    retry_backoff_with_jitter_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    // Expected responses, oldest first
    t_outcome    expected_q[$];
    int unsigned error_count = 0;
    int unsigned items_sent  = 0;
    int          burst_left  = 0;
    bit          quiet_mode  = 1'b0;
    logic [15:0] ready_pattern = '1;
    int unsigned pattern_age = 0;

    // Shadow of the block's registers and retry state
    logic [31:0] initial_m    = '0;
    logic [31:0] max_m        = '0;
    logic [7:0]  jitter_m     = '0;
    logic        in_flight_m  = 1'b0;
    logic        rerun_m      = 1'b0;
    logic [15:0] fail_count_m = '0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // floor(x * k / 100), saturated to the time width
    function automatic longint unsigned pct_of(longint unsigned x, longint unsigned k);
        longint unsigned prod;
        prod = x * k / PERCENT;
        return (prod > TIME_ALL) ? TIME_ALL : prod;
    endfunction

    function automatic logic [31:0] backoff_delay(logic [15:0] count, logic [31:0] hint,
                                                  logic [7:0] pick);
        longint unsigned init_v, cap, d, jit, pct, lo, hi;
        int unsigned     n;
        bit              done;
        if (hint != '0)
            return hint;
        init_v = initial_m;
        cap    = (max_m == '0) ? init_v : max_m;
        d      = init_v;
        done   = 1'b0;
        // Double once per earlier failure, stop at the cap
        for (n = 0; n < count && !done; n++) begin
            if (d > cap / 2) begin
                d    = cap;
                done = 1'b1;
            end else if (d == 0) begin
                done = 1'b1;
            end else begin
                d = d * 2;
                if (d >= cap) begin
                    d    = cap;
                    done = 1'b1;
                end
            end
        end
        jit = (jitter_m > PERCENT) ? PERCENT : jitter_m;
        if (jit == 0)
            return 32'(d);
        pct = (pick > PERCENT) ? PERCENT : pick;
        lo  = pct_of(d, PERCENT - jit);
        hi  = pct_of(d, PERCENT + jit);
        if (lo < init_v)
            lo = init_v;
        if (hi > cap)
            hi = cap;
        if (hi <= lo)
            return 32'(lo);
        return 32'(lo + pct_of(hi - lo, pct));
    endfunction

    // Advance the shadow state by one request and return its response
    function automatic t_outcome predict_outcome(logic [OP_W-1:0] op, logic [31:0] hint,
                                                 logic [7:0] pick);
        t_outcome res;
        res.action = ACT_NONE;
        res.delay  = '0;
        case (op)
            OP_REQUEST: begin
                if (in_flight_m) begin
                    rerun_m    = 1'b1;
                    res.action = ACT_IN_FLIGHT;
                end else begin
                    in_flight_m = 1'b1;
                    res.action  = ACT_START;
                end
            end
            OP_ACCEPTED, OP_CLEAR: begin
                in_flight_m  = 1'b0;
                rerun_m      = 1'b0;
                fail_count_m = '0;
            end
            OP_RETRY_FAIL: begin
                in_flight_m = 1'b0;
                if (rerun_m) begin
                    rerun_m      = 1'b0;
                    fail_count_m = '0;
                    in_flight_m  = 1'b1;
                    res.action   = ACT_START;
                end else begin
                    res.action = ACT_RETRY;
                    res.delay  = backoff_delay(fail_count_m, hint, pick);
                    if (fail_count_m != '1)
                        fail_count_m = fail_count_m + 1'b1;
                end
            end
            OP_TERM_FAIL: begin
                in_flight_m = 1'b0;
                rerun_m     = 1'b0;
                res.action  = ACT_STOP;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic logic [31:0] pick_hint();
        case ($urandom_range(0, 9))
            7:       return $urandom;
            8:       return $urandom_range(1, 5000);
            9:       return TIME_ALL;
            default: return '0;
        endcase
    endfunction

    function automatic logic [7:0] pick_percentile();
        return 8'($urandom_range(0, 1) ? $urandom_range(0, 100) : $urandom_range(0, 255));
    endfunction

    // Receiver: stall on a rotating pattern that is reloaded at random when its age counter wraps
    always @(posedge i_clk) begin : drive_ready
        logic [15:0] next_pattern;
        next_pattern = {ready_pattern[0], ready_pattern[15:1]};
        if (pattern_age == 0) begin
            case ($urandom_range(0, 3))
                0:       next_pattern = '1;
                1:       next_pattern = 16'($urandom);
                2:       next_pattern = 16'($urandom | $urandom);
                default: next_pattern = 16'(($urandom & $urandom) | 32'h0000_0001);
            endcase
        end
        ready_pattern <= next_pattern;
        pattern_age   <= (pattern_age == 47) ? 0 : pattern_age + 1;
        rsp_ch.ready  <= quiet_mode | next_pattern[0];
    end

    // Compare each response with the oldest expectation
    always @(negedge i_clk) begin : check_responses
        t_outcome want;
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (expected_q.size() == 0) begin
                if (error_count < MAX_SHOWN)
                    $display("unexpected response: action %0d delay %0d",
                             rsp_ch.action, rsp_ch.delay);
                error_count++;
            end else begin
                want = expected_q.pop_front();
                if (rsp_ch.action !== want.action || rsp_ch.delay !== want.delay) begin
                    if (error_count < MAX_SHOWN)
                        $display("mismatch: action exp %0d got %0d, delay exp %0d got %0d",
                                 want.action, rsp_ch.action, want.delay, rsp_ch.delay);
                    error_count++;
                end
            end
        end
    end

    // Send one request, with burst gaps unless idling is off
    task automatic send_request(input logic [OP_W-1:0] op, input logic [31:0] hint,
                                input logic [7:0] pick);
        int unsigned gap;
        bit          taken;
        gap = 0;
        if (!quiet_mode) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 20);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
            burst_left--;
        end
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.op          <= op;
        req_ch.server_hint <= hint;
        req_ch.jitter_pick <= pick;
        do begin
            @(negedge i_clk);
            taken = req_ch.ready;
            @(posedge i_clk);
        end while (!taken);
        expected_q.push_back(predict_outcome(op, hint, pick));
        items_sent++;
    endtask

    // Hold off until every response is back and the block has settled
    task automatic finish_outstanding();
        req_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all three registers back to back
    task automatic load_registers(input logic [31:0] init_v, input logic [31:0] max_v,
                                  input logic [7:0] jit_v);
        t_cfg_idx    order[3];
        logic [31:0] values[3];
        bit          taken;
        order[0]  = CFG_INITIAL;
        order[1]  = CFG_MAX;
        order[2]  = CFG_JITTER;
        values[0] = init_v;
        values[1] = max_v;
        values[2] = {24'($urandom_range(0, 24'hFF_FFFF)), jit_v};
        for (int n = 0; n < 3; n++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= order[n];
            cfg_ch.data  <= values[n];
            do begin
                @(negedge i_clk);
                taken = cfg_ch.ready;
                @(posedge i_clk);
            end while (!taken);
            case (order[n])
                CFG_INITIAL: initial_m = values[n];
                CFG_MAX:     max_m     = values[n];
                default:     jitter_m  = values[n][7:0];
            endcase
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // Registers at their reset values: zero delays, coalescing, hint passthrough
    task automatic test_default_registers();
        send_request(OP_REQUEST, '0, '0);
        send_request(OP_RETRY_FAIL, '0, '0);
        send_request(OP_RETRY_FAIL, TIME_ALL, 8'hFF);
        send_request(OP_REQUEST, '0, '0);
        send_request(OP_REQUEST, TIME_ALL, 8'hFF);
        send_request(OP_RETRY_FAIL, '0, 8'd50);
    endtask

    // Every op, doubling up to the cap, unused op codes
    task automatic test_directed_ops();
        finish_outstanding();
        load_registers(32'd100, 32'd1000, 8'd0);
        send_request(OP_CLEAR, '0, '0);
        repeat (6) send_request(OP_RETRY_FAIL, '0, 8'd100);
        send_request(OP_RETRY_FAIL, 32'd7, '0);
        send_request(OP_ACCEPTED, '0, '0);
        send_request(OP_REQUEST, '0, '0);
        send_request(OP_TERM_FAIL, '0, '0);
        for (int u = OP_UNUSED_FIRST; u <= OP_CODE_TOP; u++)
            send_request(OP_W'(u), TIME_ALL, 8'hFF);
    endtask

    // Jitter band edges, saturated jitter, initial above max, saturating band
    task automatic test_jitter_edges();
        finish_outstanding();
        load_registers(32'd1000, 32'd8000, 8'd50);
        send_request(OP_RETRY_FAIL, '0, 8'd0);
        send_request(OP_RETRY_FAIL, '0, 8'd100);
        send_request(OP_RETRY_FAIL, '0, 8'd255);
        finish_outstanding();
        load_registers(32'd1000, 32'd8000, 8'd255);
        send_request(OP_RETRY_FAIL, '0, 8'd50);
        finish_outstanding();
        load_registers(32'd500, 32'd300, 8'd30);
        send_request(OP_CLEAR, '0, '0);
        send_request(OP_RETRY_FAIL, '0, 8'd100);
        send_request(OP_RETRY_FAIL, '0, 8'd0);
        finish_outstanding();
        load_registers(TIME_ALL, '0, 8'd100);
        send_request(OP_RETRY_FAIL, '0, 8'd255);
    endtask

    // Drive the failure count deep back to back; after the first failure the delay stays at the cap
    task automatic test_deep_failures();
        finish_outstanding();
        load_registers(32'd2, 32'd3, 8'd0);
        quiet_mode = 1'b1;
        send_request(OP_CLEAR, '0, '0);
        for (int n = 0; n < DEEP_FAILS; n++)
            send_request(OP_RETRY_FAIL, '0, '0);
        finish_outstanding();
        quiet_mode = 1'b0;
    endtask

    // Registration attempts with random content, plus noise, over several settings
    task automatic test_random_traffic();
        logic [31:0] init_v, max_v;
        logic [7:0]  jit_v;
        int unsigned phase_end, fail_pct, dup_pct, roll;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            finish_outstanding();
            case (phase)
                0: begin
                    init_v = $urandom_range(1, 5000);
                    max_v  = '0;
                    jit_v  = 8'($urandom_range(1, 100));
                end
                1: begin
                    init_v = 32'd1;
                    max_v  = TIME_ALL;
                    jit_v  = 8'd100;
                end
                2: begin
                    init_v = TIME_ALL;
                    max_v  = TIME_ALL;
                    jit_v  = 8'd255;
                end
                3: begin
                    init_v = $urandom_range(2000, 9000);
                    max_v  = $urandom_range(100, 1500);
                    jit_v  = 8'($urandom_range(0, 255));
                end
                4: begin
                    init_v = '0;
                    max_v  = $urandom;
                    jit_v  = 8'($urandom_range(0, 255));
                end
                default: begin
                    init_v = $urandom >> $urandom_range(0, 31);
                    max_v  = $urandom;
                    jit_v  = 8'($urandom_range(0, 255));
                end
            endcase
            load_registers(init_v, max_v, jit_v);
            // Odd phases are failure storms that drive the count deep
            fail_pct  = (phase % 2 == 1) ? 95 : 70;
            dup_pct   = (phase % 2 == 1) ? 3 : 25;
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 99) < 15) begin
                    send_request(OP_W'($urandom_range(0, OP_CODE_TOP)), $urandom,
                                 8'($urandom));
                end else begin
                    send_request(OP_REQUEST, $urandom, 8'($urandom));
                    if ($urandom_range(0, 99) < dup_pct)
                        repeat ($urandom_range(1, 2))
                            send_request(OP_REQUEST, $urandom, 8'($urandom));
                    roll = $urandom_range(0, 99);
                    if (roll < fail_pct)
                        send_request(OP_RETRY_FAIL, pick_hint(), pick_percentile());
                    else if (roll < fail_pct + 2)
                        send_request(OP_CLEAR, $urandom, 8'($urandom));
                    else if (roll < fail_pct + 10)
                        send_request(OP_TERM_FAIL, $urandom, 8'($urandom));
                    else
                        send_request(OP_ACCEPTED, $urandom, 8'($urandom));
                end
            end
        end
    endtask

    initial begin : run_tests
        req_ch.valid       = 1'b0;
        req_ch.op          = '0;
        req_ch.server_hint = '0;
        req_ch.jitter_pick = '0;
        rsp_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_INITIAL;
        cfg_ch.data        = '0;
        i_rst_n            = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_registers();
        test_directed_ops();
        test_jitter_edges();
        test_deep_failures();
        test_random_traffic();
        finish_outstanding();
        if (error_count == 0 && expected_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Drop the run if it hangs
    initial begin : watchdog
        #40_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
